/* hw/rtl/priority_bitmap_round_robin_scheduler_core_macros.svh */
// Assertion macros for the ready-queue scheduler core.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef PRIORITY_BITMAP_ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH
`define PRIORITY_BITMAP_ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define PBRR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Expression holds at every clock edge out of reset.
`define PBRR_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

/* hw/rtl/pbrr_pkg.sv */
// Package for the ready-queue scheduler: transaction structs, request and
// status codes, field widths and parameter defaults. No dependencies.
package pbrr_pkg;

    localparam int TASK_W   = 5;
    localparam int PRIO_W   = 3;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    // task ids the request field can name
    localparam int MAX_SLOTS = 2 ** TASK_W;

    localparam int DEF_MAX_TASKS   = 32;
    localparam int DEF_PRIO_LEVELS = 8;

    localparam logic [REQ_W-1:0] REQ_ADD      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PICK     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE_READY = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] task_prio;
    } request_t;

    typedef struct packed {
        logic [TASK_W-1:0]   picked_task;
        logic [PRIO_W-1:0]   picked_prio;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

/* hw/rtl/priority_bitmap_round_robin_scheduler_core.sv */
// Each accepted request is held in req_reg; its result is registered in rsp_reg
// with done high. Throughput: one transaction per cycle; busy is never raised.
// The single pass reads head, tail and link tables once each in flops.
// Reset clears the ready bitmap, the queued flags and the control flops; the
// link, level, head and tail tables are not cleared and need no clearing pass.
// Depends on pbrr_pkg and priority_bitmap_round_robin_scheduler_core_macros.svh.
`include "priority_bitmap_round_robin_scheduler_core_macros.svh"

module priority_bitmap_round_robin_scheduler_core #(
    parameter int MAX_TASKS   = pbrr_pkg::DEF_MAX_TASKS,
    parameter int PRIO_LEVELS = pbrr_pkg::DEF_PRIO_LEVELS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pbrr_pkg::request_t req,
    output logic               done,
    output pbrr_pkg::result_t  rsp
);

    localparam int TASK_W    = pbrr_pkg::TASK_W;
    localparam int PRIO_W    = pbrr_pkg::PRIO_W;
    localparam int NUM_SLOTS = (MAX_TASKS < pbrr_pkg::MAX_SLOTS) ? MAX_TASKS
                                                                  : pbrr_pkg::MAX_SLOTS;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LVL_W     = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(PRIO_LEVELS - 1);

    // control and state
    logic                   req_valid_reg;
    pbrr_pkg::request_t     req_reg;
    logic                   done_reg;
    pbrr_pkg::result_t      rsp_reg;
    pbrr_pkg::result_t      rsp_next;
    logic [PRIO_LEVELS-1:0] ready_levels_reg;
    logic [PRIO_LEVELS-1:0] ready_levels_next;
    logic [NUM_SLOTS-1:0]   task_queued_reg;
    logic [NUM_SLOTS-1:0]   task_queued_next;

    logic [LVL_W-1:0]  task_level_reg [NUM_SLOTS];
    logic [SLOT_W-1:0] next_link_reg  [NUM_SLOTS];
    logic [SLOT_W-1:0] prev_link_reg  [NUM_SLOTS];
    logic [SLOT_W-1:0] level_head_reg [PRIO_LEVELS];
    logic [SLOT_W-1:0] level_tail_reg [PRIO_LEVELS];

    // decode
    logic              accept;
    logic              tid_ok;
    logic [SLOT_W-1:0] tid;
    logic [LVL_W-1:0]  add_lvl;
    logic [LVL_W-1:0]  pick_lvl;
    logic              any_ready;
    logic [LVL_W-1:0]  lvl_sel;
    logic [SLOT_W-1:0] head_q;
    logic [SLOT_W-1:0] tail_q;
    logic              lvl_ready;
    logic [SLOT_W-1:0] link_addr;
    logic [SLOT_W-1:0] nxt_q;
    logic [SLOT_W-1:0] prv_q;
    logic              tid_queued;

    // table write ports
    logic              next_we;
    logic [SLOT_W-1:0] next_wa;
    logic [SLOT_W-1:0] next_wd;
    logic              prev_we;
    logic [SLOT_W-1:0] prev_wa;
    logic [SLOT_W-1:0] prev_wd;
    logic              level_we;
    logic              head_we;
    logic [SLOT_W-1:0] head_wd;
    logic              tail_we;
    logic [SLOT_W-1:0] tail_wd;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    assign tid_ok     = (int'(req_reg.task_id) < NUM_SLOTS);
    assign tid        = req_reg.task_id[SLOT_W-1:0];
    assign tid_queued = task_queued_reg[tid];
    assign add_lvl    = (int'(req_reg.task_prio) < PRIO_LEVELS) ? req_reg.task_prio[LVL_W-1:0]
                                                                : TOP_LVL;
    assign any_ready  = |ready_levels_reg;

    always_comb
    begin
        pick_lvl = TOP_LVL;
        for (int i = PRIO_LEVELS - 1; i >= 0; i--)
        begin
            if (ready_levels_reg[i])
            begin
                pick_lvl = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        case (req_reg.req_type)
            pbrr_pkg::REQ_ADD:    lvl_sel = add_lvl;
            pbrr_pkg::REQ_REMOVE: lvl_sel = task_level_reg[tid];
            default:              lvl_sel = pick_lvl;
        endcase
    end

    assign head_q    = level_head_reg[lvl_sel];
    assign tail_q    = level_tail_reg[lvl_sel];
    assign lvl_ready = ready_levels_reg[lvl_sel];
    assign link_addr = (req_reg.req_type == pbrr_pkg::REQ_PICK) ? head_q : tid;
    assign nxt_q     = next_link_reg[link_addr];
    assign prv_q     = prev_link_reg[tid];

    always_comb
    begin
        ready_levels_next = ready_levels_reg;
        task_queued_next  = task_queued_reg;
        next_we  = 1'b0;
        next_wa  = tail_q;
        next_wd  = tid;
        prev_we  = 1'b0;
        prev_wa  = tid;
        prev_wd  = tail_q;
        level_we = 1'b0;
        head_we  = 1'b0;
        head_wd  = tid;
        tail_we  = 1'b0;
        tail_wd  = tid;
        rsp_next = '{picked_task: '0, picked_prio: '0, status: pbrr_pkg::ST_OK};

        if (req_valid_reg)
        begin
            case (req_reg.req_type)
                pbrr_pkg::REQ_ADD:
                begin
                    if (!tid_ok)
                    begin
                        rsp_next.status = pbrr_pkg::ST_NOT_QUEUED;
                    end
                    else if (tid_queued)
                    begin
                        rsp_next.status = pbrr_pkg::ST_ALREADY;
                    end
                    else
                    begin
                        if (lvl_ready)
                        begin
                            next_we = 1'b1;
                            prev_we = 1'b1;
                        end
                        else
                        begin
                            head_we = 1'b1;
                            ready_levels_next[lvl_sel] = 1'b1;
                        end
                        tail_we  = 1'b1;
                        level_we = 1'b1;
                        task_queued_next[tid] = 1'b1;
                    end
                end
                pbrr_pkg::REQ_REMOVE:
                begin
                    if (!tid_ok || !tid_queued)
                    begin
                        rsp_next.status = pbrr_pkg::ST_NOT_QUEUED;
                    end
                    else
                    begin
                        if (head_q == tid && tail_q == tid)
                        begin
                            ready_levels_next[lvl_sel] = 1'b0;
                        end
                        else if (head_q == tid)
                        begin
                            head_we = 1'b1;
                            head_wd = nxt_q;
                        end
                        else if (tail_q == tid)
                        begin
                            tail_we = 1'b1;
                            tail_wd = prv_q;
                        end
                        else
                        begin
                            next_we = 1'b1;
                            next_wa = prv_q;
                            next_wd = nxt_q;
                            prev_we = 1'b1;
                            prev_wa = nxt_q;
                            prev_wd = prv_q;
                        end
                        task_queued_next[tid] = 1'b0;
                    end
                end
                pbrr_pkg::REQ_PICK:
                begin
                    if (!any_ready)
                    begin
                        rsp_next.status = pbrr_pkg::ST_NONE_READY;
                    end
                    else
                    begin
                        // head moves to the tail unless it is alone
                        if (tail_q != head_q)
                        begin
                            head_we = 1'b1;
                            head_wd = nxt_q;
                            next_we = 1'b1;
                            next_wd = head_q;
                            prev_we = 1'b1;
                            prev_wa = head_q;
                            tail_we = 1'b1;
                            tail_wd = head_q;
                        end
                        rsp_next.picked_task = TASK_W'(head_q);
                        rsp_next.picked_prio = PRIO_W'(pick_lvl);
                    end
                end
                default:
                begin
                    rsp_next.status = pbrr_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            done_reg         <= 1'b0;
            ready_levels_reg <= '0;
            task_queued_reg  <= '0;
        end
        else
        begin
            req_valid_reg    <= accept;
            done_reg         <= req_valid_reg;
            ready_levels_reg <= ready_levels_next;
            task_queued_reg  <= task_queued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
        if (next_we)
        begin
            next_link_reg[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_link_reg[prev_wa] <= prev_wd;
        end
        if (level_we)
        begin
            task_level_reg[tid] <= lvl_sel;
        end
        if (head_we)
        begin
            level_head_reg[lvl_sel] <= head_wd;
        end
        if (tail_we)
        begin
            level_tail_reg[lvl_sel] <= tail_wd;
        end
    end

    `PBRR_ASSERT_IMPLIES(a_done_after_work, done, $past(req_valid_reg),
        "result strobe without a transaction in process")
    `PBRR_ASSERT_IMPLIES(a_none_ready_empty, done && rsp.status == pbrr_pkg::ST_NONE_READY,
        $past(ready_levels_reg) == '0, "no ready task reported while a level was ready")
    `PBRR_ASSERT_ALWAYS(a_levels_le_tasks,
        $countones(ready_levels_reg) <= $countones(task_queued_reg),
        "more ready levels than queued tasks")

endmodule
